[rtl/core/cks_pkg.sv]
// Shared constants, codes and types of the colour keyframe sampler.
package cks_pkg;

   localparam int CKS_TABLE_DEPTH = 4096;

   localparam int INDEX_W = 12;
   localparam int BYTE_W  = 8;
   localparam int FRAME_W = 16;
   localparam int BLEND_W = 3;
   localparam int LEN_W   = 16;
   localparam int COUNT_W = 16;
   // Track offset sums stay below 2^18 for every input pattern.
   localparam int X_W     = 18;

   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   localparam logic [BLEND_W-1:0] BLEND_DIRECT = 3'd1;
   localparam logic [LEN_W-1:0]   LEN_CONSTANT = 16'd1;

   typedef struct packed {
      logic               kind;
      logic [INDEX_W-1:0] table_index;
      logic [BYTE_W-1:0]  write_byte;
      logic [FRAME_W-1:0] frame;
      logic [BLEND_W-1:0] blend;
      logic [LEN_W-1:0]   track_length;
   } req_type;

   typedef struct packed {
      logic              is_write;
      logic [BYTE_W-1:0] write_byte;
      logic              interp;
      logic [1:0]        shift;
      logic [1:0]        weight;
   } side_type;

endpackage

[rtl/core/cks_if.sv]
// Channel interfaces of the colour keyframe sampler: request, response and register write.
interface cks_req_if;
   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic [cks_pkg::INDEX_W-1:0] table_index;
   logic [cks_pkg::BYTE_W-1:0]  write_byte;
   logic [cks_pkg::FRAME_W-1:0] frame;
   logic [cks_pkg::BLEND_W-1:0] blend;
   logic [cks_pkg::LEN_W-1:0]   track_length;

   modport source (output valid, kind, table_index, write_byte, frame, blend, track_length,
                   input ready);
   modport sink (input valid, kind, table_index, write_byte, frame, blend, track_length,
                 output ready);
endinterface

interface cks_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [cks_pkg::BYTE_W-1:0] colour_value;

   modport source (output valid, colour_value, input ready);
   modport sink (input valid, colour_value, output ready);
endinterface

interface cks_csr_if;
   logic                        valid;
   logic                        ready;
   logic [cks_pkg::COUNT_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

[rtl/core/cks_ram.sv]
// Generic RAM with one write port and two registered read ports.
module cks_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

[rtl/core/cks_addr_pipe.sv]
// Address pipeline: decodes a beat, forms the track offset and reduces it modulo the table depth.
module cks_addr_pipe #(
   parameter int TABLE_DEPTH = cks_pkg::CKS_TABLE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  cks_pkg::req_type                in_req,
   input  logic [cks_pkg::COUNT_W-1:0]     fc_m1,
   input  logic                            fc_zero,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [$clog2(TABLE_DEPTH)-1:0]  out_addr,
   output cks_pkg::side_type               out_side
);
   import cks_pkg::*;

   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int RECIP_SHIFT = X_W + ADDR_W;
   localparam int RECIP_W     = X_W + 2;
   localparam logic [63:0] RECIP_WIDE =
      ((64'd1 << RECIP_SHIFT) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH);
   localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'(RECIP_WIDE);
   localparam logic [X_W-1:0]     DEPTH_X = X_W'(TABLE_DEPTH);

   // Stage registers.
   logic              s1_valid_ff;
   req_type           s1_req_ff;
   logic              s2_valid_ff;
   logic [INDEX_W-1:0] s2_base_ff;
   logic [FRAME_W:0]  s2_off_a_ff;
   logic [FRAME_W-1:0] s2_off_b_ff;
   side_type          s2_side_ff;
   logic              s3_valid_ff;
   logic [X_W-1:0]    s3_x_ff;
   side_type          s3_side_ff;
   logic              s4_valid_ff;
   logic [X_W-1:0]    s4_x_ff;
   logic [X_W-1:0]    s4_q_ff;
   side_type          s4_side_ff;
   logic              s5_valid_ff;
   logic [ADDR_W-1:0] s5_addr_ff;
   side_type          s5_side_ff;

   logic r1, r2, r3, r4, r5;

   // Stage 1 decode.
   logic [1:0]         shift;
   logic [FRAME_W-1:0] low_mask;
   logic [FRAME_W-1:0] limit;
   logic [FRAME_W:0]   diff;
   logic [FRAME_W:0]   wrap_off;
   logic [FRAME_W:0]   last_off;
   logic [FRAME_W-1:0] frame_dec;
   logic               is_last;
   logic               len_one;
   logic               direct;
   logic [FRAME_W:0]   s2_off_a_in;
   logic [FRAME_W-1:0] s2_off_b_in;
   side_type           s2_side_in;

   logic [X_W-1:0]         s3_x_in;
   logic [X_W+RECIP_W-1:0] prod;
   logic [X_W-1:0]         s4_q_in;
   logic [2*X_W-1:0]       qd;
   logic [X_W-1:0]         rem;

   assign r5       = !s5_valid_ff || out_ready;
   assign r4       = !s4_valid_ff || r5;
   assign r3       = !s3_valid_ff || r4;
   assign r2       = !s2_valid_ff || r3;
   assign r1       = !s1_valid_ff || r2;
   assign in_ready = r1;

   always_comb begin
      shift     = s1_req_ff.blend[2:1];
      low_mask  = (16'd1 << shift) - 16'd1;
      limit     = fc_m1 & ~low_mask;
      diff      = {1'b0, s1_req_ff.frame} - {1'b0, limit};
      wrap_off  = {1'b0, s1_req_ff.frame} + (17'd1 << shift);
      is_last   = fc_zero || !diff[FRAME_W];
      last_off  = fc_zero ? wrap_off : diff;
      frame_dec = s1_req_ff.frame >> shift;
      len_one   = s1_req_ff.track_length == LEN_CONSTANT;
      direct    = s1_req_ff.blend == BLEND_DIRECT;

      s2_side_in.is_write   = s1_req_ff.kind == KIND_WRITE;
      s2_side_in.write_byte = s1_req_ff.write_byte;
      s2_side_in.shift      = shift;
      s2_side_in.weight     = {s1_req_ff.frame[1] & shift[1], s1_req_ff.frame[0]};
      s2_side_in.interp     = 1'b0;
      s2_off_a_in           = '0;
      s2_off_b_in           = '0;
      if (s1_req_ff.kind == KIND_WRITE || len_one) begin
         s2_off_a_in = '0;
      end else if (direct) begin
         s2_off_a_in = {1'b0, s1_req_ff.frame};
      end else if (is_last) begin
         s2_off_a_in = last_off;
         s2_off_b_in = frame_dec;
      end else begin
         s2_off_b_in       = frame_dec;
         s2_side_in.interp = 1'b1;
      end
   end

   assign s3_x_in = X_W'(s2_base_ff) + X_W'(s2_off_a_ff) + X_W'(s2_off_b_ff);

   // Floor division by the depth as a multiply by a rounded-up reciprocal;
   // exact for every sum below 2^X_W.
   assign prod    = {{RECIP_W{1'b0}}, s3_x_ff} * {{X_W{1'b0}}, RECIP};
   assign s4_q_in = X_W'(prod >> RECIP_SHIFT);

   assign qd  = {{X_W{1'b0}}, s4_q_ff} * {{X_W{1'b0}}, DEPTH_X};
   assign rem = s4_x_ff - qd[X_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (r1) s1_valid_ff <= in_valid;
         if (r2) s2_valid_ff <= s1_valid_ff;
         if (r3) s3_valid_ff <= s2_valid_ff;
         if (r4) s4_valid_ff <= s3_valid_ff;
         if (r5) s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (r1) begin
         s1_req_ff <= in_req;
      end
      if (r2) begin
         s2_base_ff  <= s1_req_ff.table_index;
         s2_off_a_ff <= s2_off_a_in;
         s2_off_b_ff <= s2_off_b_in;
         s2_side_ff  <= s2_side_in;
      end
      if (r3) begin
         s3_x_ff    <= s3_x_in;
         s3_side_ff <= s2_side_ff;
      end
      if (r4) begin
         s4_x_ff    <= s3_x_ff;
         s4_q_ff    <= s4_q_in;
         s4_side_ff <= s3_side_ff;
      end
      if (r5) begin
         s5_addr_ff <= rem[ADDR_W-1:0];
         s5_side_ff <= s4_side_ff;
      end
   end

   assign out_valid = s5_valid_ff;
   assign out_addr  = s5_addr_ff;
   assign out_side  = s5_side_ff;

   // The reciprocal quotient must be exact, so the remainder lands inside the table.
   a_rem_in_range: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff |-> rem < DEPTH_X)
      else $error("address reduction left a remainder at or above the depth");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (s5_valid_ff && !out_ready) |=>
         (s5_valid_ff && $stable(s5_addr_ff) && $stable(s5_side_ff)))
      else $error("stalled address beat changed or vanished");

endmodule

[rtl/core/cks_mem_stage.sv]
// Table stage: writes bytes, reads one or two keyframes and blends them into the result register.
module cks_mem_stage #(
   parameter int TABLE_DEPTH = cks_pkg::CKS_TABLE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [$clog2(TABLE_DEPTH)-1:0]  in_addr,
   input  cks_pkg::side_type               in_side,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [cks_pkg::BYTE_W-1:0]      rsp_value
);
   import cks_pkg::*;

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);

   logic              s6_valid_ff;
   side_type          s6_side_ff;
   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] rsp_value_ff;

   logic              en6;
   logic              en7;
   logic [ADDR_W-1:0] next_addr;
   logic              wr_en;
   logic [BYTE_W-1:0] v1;
   logic [BYTE_W-1:0] v2;
   logic [3:0]        w1;
   logic [11:0]       sum;
   logic [BYTE_W-1:0] value_in;

   assign en7      = !rsp_valid_ff || rsp_ready;
   assign en6      = !s6_valid_ff || en7;
   assign in_ready = en6;

   assign next_addr = (in_addr == LAST_ADDR) ? '0 : in_addr + ADDR_W'(1);
   assign wr_en     = en6 && in_valid && in_side.is_write;

   cks_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (in_addr),
      .wr_data   (in_side.write_byte),
      .rd_en     (en6),
      .rd_addr_a (in_addr),
      .rd_addr_b (next_addr),
      .rd_data_a (v1),
      .rd_data_b (v2)
   );

   always_comb begin
      w1  = (4'd1 << s6_side_ff.shift) - {2'b00, s6_side_ff.weight};
      sum = 12'(v1) * 12'(w1) + 12'(v2) * {10'd0, s6_side_ff.weight};
      if (s6_side_ff.interp) begin
         value_in = BYTE_W'(sum >> s6_side_ff.shift);
      end else begin
         value_in = v1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en6) s6_valid_ff  <= in_valid && !in_side.is_write;
         if (en7) rsp_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en6) begin
         s6_side_ff <= in_side;
      end
      if (en7) begin
         rsp_value_ff <= value_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

   // A table write ends here and never turns into a result.
   a_write_drops: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready && in_side.is_write) |=> !s6_valid_ff)
      else $error("write beat reached the blend stage");

   a_sample_advances: assert property (@(posedge clock) disable iff (reset)
      (s6_valid_ff && en7) |=> rsp_valid_ff)
      else $error("sample beat lost between blend and result register");

endmodule

[rtl/core/colour_keyframe_sampler.sv]
// Top level of the colour keyframe sampler: register port, address pipeline and table stage.
//
//   channel   dir   handshake     beat contents
//   req_bus   in    valid/ready   kind, table_index, write_byte, frame, blend, track_length
//   rsp_bus   out   valid/ready   colour_value
//   csr_bus   in    valid/ready   data (frame total)
//
// One beat is taken per cycle unless rsp_bus stalls; sample results come in request order.
// A sample beat passes every stage up to the result register; the depth is set
// by the offset adds, the two multiplies of the modulo-depth reduction and the RAM read.
// Write beats pass the same address stages, update the table at the RAM and produce no result.
// Each stage advances whenever the one after it is empty or moving, so bubbles close up
// and a stall on rsp_bus backs up stage by stage without dropping a beat.
// Reset is synchronous; it clears the valid bits and sets the frame total to one. The table
// itself is not cleared and needs no clearing pass.
module colour_keyframe_sampler #(
   parameter int TABLE_DEPTH = cks_pkg::CKS_TABLE_DEPTH
) (
   input logic        clock,
   input logic        reset,
   cks_req_if.sink    req_bus,
   cks_rsp_if.source  rsp_bus,
   cks_csr_if.sink    csr_bus
);
   import cks_pkg::*;

   localparam int ADDR_W = $clog2(TABLE_DEPTH);

   // The frame total is kept as the total minus one plus a zero flag; that is all the
   // limit computation needs. Its reset value is one.
   logic [COUNT_W-1:0] fc_m1_ff;
   logic [COUNT_W-1:0] fc_m1_in;
   logic               fc_zero_ff;
   logic               fc_zero_in;

   req_type           req_data;
   logic              addr_valid;
   logic              addr_ready;
   logic [ADDR_W-1:0] addr;
   side_type          side;

   // The register port never stalls.
   assign csr_bus.ready = 1'b1;
   assign fc_m1_in      = csr_bus.data - COUNT_W'(1);
   assign fc_zero_in    = csr_bus.data == '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         fc_m1_ff   <= '0;
         fc_zero_ff <= 1'b0;
      end else if (csr_bus.valid) begin
         fc_m1_ff   <= fc_m1_in;
         fc_zero_ff <= fc_zero_in;
      end
   end

   always_comb begin
      req_data.kind         = req_bus.kind;
      req_data.table_index  = req_bus.table_index;
      req_data.write_byte   = req_bus.write_byte;
      req_data.frame        = req_bus.frame;
      req_data.blend        = req_bus.blend;
      req_data.track_length = req_bus.track_length;
   end

   // Stages one to five: decode, offset sum, reciprocal multiply, remainder.
   cks_addr_pipe #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_addr_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_req    (req_data),
      .fc_m1     (fc_m1_ff),
      .fc_zero   (fc_zero_ff),
      .out_valid (addr_valid),
      .out_ready (addr_ready),
      .out_addr  (addr),
      .out_side  (side)
   );

   // Stage six is the RAM read, stage seven the blended result register.
   cks_mem_stage #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_mem_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (addr_valid),
      .in_ready  (addr_ready),
      .in_addr   (addr),
      .in_side   (side),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .rsp_value (rsp_bus.colour_value)
   );

   // A zero frame count is the only way the flag is set.
   a_zero_flag: assert property (@(posedge clock) disable iff (reset)
      (csr_bus.valid && csr_bus.ready) |=> (fc_zero_ff == ($past(csr_bus.data) == '0)))
      else $error("zero frame count flag does not follow the written value");

   a_zero_consistent: assert property (@(posedge clock) disable iff (reset)
      fc_zero_ff |-> (fc_m1_ff == '1))
      else $error("frame count register and zero flag disagree");

endmodule

[sim/colour_keyframe_sampler_tb.sv]
// Self-checking testbench of colour_keyframe_sampler: directed and random beats against a local predictor.
`timescale 1ns / 1ps
module colour_keyframe_sampler_tb;
   import cks_pkg::*;

   // A sample beat and a write travel the same address stages; only the sample gives a result.
   localparam int LATENCY     = 6;
   localparam int SETTLE      = 2 * LATENCY;
   localparam int CYCLE_LIMIT = 200000;
   localparam int REPORT_MAX  = 10;
   localparam int PHASES      = 6;
   localparam int PHASE_BEATS = 120;
   localparam logic [INDEX_W-1:0] TOP_INDEX = INDEX_W'(CKS_TABLE_DEPTH - 1);

   // Where a sample reads the table: one key, or two neighboring keys and a blend weight.
   typedef struct packed {
      logic               blended;
      logic [1:0]         shift;
      logic [1:0]         weight;
      logic [INDEX_W-1:0] first_addr;
      logic [INDEX_W-1:0] second_addr;
   } track_read_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cks_req_if req_bus ();
   cks_rsp_if rsp_bus ();
   cks_csr_if csr_bus ();

   colour_keyframe_sampler dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #10 clock = ~clock;

   // Beats waiting for the driver, and colors still owed by the block, oldest first.
   req_type            pending_beats [$];
   logic [BYTE_W-1:0]  expected_colours [$];

   // Predictor state: the table as the block should hold it and the frame total in force.
   logic [BYTE_W-1:0]  colour_mem [CKS_TABLE_DEPTH];
   logic [COUNT_W-1:0] frame_total_reg = 16'd1;

   // Generator state. The table is undefined until written, so the generator tracks which
   // entries it has already queued a write for and never lets a sample read any other.
   bit                 filled [CKS_TABLE_DEPTH];
   logic [COUNT_W-1:0] planned_frame_total = 16'd1;
   int unsigned        last_base = 0;
   int unsigned        beats_queued = 0;

   int send_idle_pct    = 30;
   int accept_stall_pct = 65;

   int failures      = 0;
   int cycle_count   = 0;
   int writes_seen   = 0;
   int constant_seen = 0;
   int direct_seen   = 0;
   int tail_seen     = 0;
   int blended_seen  = 0;
   int settings_used = 0;

   // Works out which entries a sample beat reads, given the frame total in force.
   // Addresses are 12 bits wide, so every sum below wraps modulo the table depth.
   function automatic track_read_type locate_track(req_type beat, logic [COUNT_W-1:0] count);
      track_read_type rd;
      int unsigned    sh;
      longint         frame_l;
      longint         last_key;
      longint         offset;
      rd       = '0;
      sh       = 32'(beat.blend) >> 1;
      frame_l  = longint'(beat.frame);
      rd.shift = sh[1:0];
      if (beat.track_length == LEN_CONSTANT) begin
         rd.first_addr = beat.table_index;
      end else if (beat.blend == BLEND_DIRECT) begin
         rd.first_addr = INDEX_W'(beat.table_index + beat.frame);
      end else begin
         // The last keyframe sits at the frame total minus one, rounded down to the
         // decimation step. A zero total counts as minus one, which puts every frame
         // past the end.
         if (count == '0) begin
            last_key = -(longint'(1) << sh);
         end else begin
            last_key = ((longint'(count) - 1) >> sh) << sh;
         end
         if (frame_l >= last_key) begin
            offset        = frame_l - last_key + (frame_l >> sh);
            rd.first_addr = INDEX_W'(longint'(beat.table_index) + offset);
         end else begin
            rd.blended     = 1'b1;
            rd.weight      = 2'(32'(beat.frame) & (sh | 1));
            rd.first_addr  = INDEX_W'(beat.table_index + (beat.frame >> sh));
            rd.second_addr = rd.first_addr + INDEX_W'(1);
         end
      end
      return rd;
   endfunction

   // Random contents for every field, so that the fields a beat does not use toggle too.
   function automatic req_type noise_beat();
      logic [63:0] noise;
      noise = {$urandom, $urandom};
      return noise[$bits(req_type)-1:0];
   endfunction

   function automatic void queue_write(logic [INDEX_W-1:0] addr, logic [BYTE_W-1:0] value);
      req_type beat;
      beat             = noise_beat();
      beat.kind        = KIND_WRITE;
      beat.table_index = addr;
      beat.write_byte  = value;
      filled[addr]     = 1'b1;
      pending_beats.push_back(beat);
      beats_queued++;
   endfunction

   // Queues a sample beat, preceded by writes to any entry it reads that is still unwritten.
   function automatic void queue_sample(logic [INDEX_W-1:0] base, logic [FRAME_W-1:0] frame,
                                        logic [BLEND_W-1:0] blend, logic [LEN_W-1:0] len);
      req_type        beat;
      track_read_type rd;
      beat              = noise_beat();
      beat.kind         = KIND_SAMPLE;
      beat.table_index  = base;
      beat.frame        = frame;
      beat.blend        = blend;
      beat.track_length = len;
      rd = locate_track(beat, planned_frame_total);
      if (!filled[rd.first_addr]) begin
         queue_write(rd.first_addr, BYTE_W'($urandom_range(255)));
      end
      if (rd.blended && !filled[rd.second_addr]) begin
         queue_write(rd.second_addr, BYTE_W'($urandom_range(255)));
      end
      pending_beats.push_back(beat);
      beats_queued++;
   endfunction

   // Holds the sender back until every queued beat is accepted and every color is back,
   // then lets the pipeline run empty for the settle time, since writes give no result.
   task automatic drain(int settle);
      while (pending_beats.size() != 0 || req_bus.valid || expected_colours.size() != 0) begin
         @(posedge clock);
      end
      repeat (settle) @(posedge clock);
   endtask

   // Writes the frame total through the register port; only called with the block idle.
   task automatic write_frame_total(logic [COUNT_W-1:0] value);
      csr_bus.data  <= value;
      csr_bus.valid <= 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid       <= 1'b0;
      planned_frame_total  = value;
      settings_used++;
   endtask

   // Request driver. A beat stays on the bus until it is taken; a new one is offered only
   // when the bus is empty or its beat is taken at this edge, and then only if the sender
   // does not choose to idle this cycle.
   always @(posedge clock) begin : req_driver
      req_type next_beat;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_beat = pending_beats.pop_front();
            req_bus.valid        <= 1'b1;
            req_bus.kind         <= next_beat.kind;
            req_bus.table_index  <= next_beat.table_index;
            req_bus.write_byte   <= next_beat.write_byte;
            req_bus.frame        <= next_beat.frame;
            req_bus.blend        <= next_beat.blend;
            req_bus.track_length <= next_beat.track_length;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Response side stalls at random, at the rate the current phase asks for.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= accept_stall_pct);
      end
   end

   // Monitor. At each edge it first applies a register write or a request beat to the
   // predictor, then checks a response beat against the oldest color still owed.
   always @(posedge clock) begin : colour_check
      req_type           beat;
      track_read_type    rd;
      int unsigned       mix;
      logic [BYTE_W-1:0] want;
      if (reset) begin
         frame_total_reg = 16'd1;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            frame_total_reg = csr_bus.data;
         end
         if (req_bus.valid && req_bus.ready) begin
            beat.kind         = req_bus.kind;
            beat.table_index  = req_bus.table_index;
            beat.write_byte   = req_bus.write_byte;
            beat.frame        = req_bus.frame;
            beat.blend        = req_bus.blend;
            beat.track_length = req_bus.track_length;
            if (beat.kind == KIND_WRITE) begin
               colour_mem[beat.table_index] = beat.write_byte;
               writes_seen++;
            end else begin
               rd = locate_track(beat, frame_total_reg);
               if (rd.blended) begin
                  // Weights sum to 2^shift, so the shift back is the truncated blend.
                  mix = colour_mem[rd.first_addr] * ((1 << rd.shift) - rd.weight)
                        + colour_mem[rd.second_addr] * rd.weight;
                  want = BYTE_W'(mix >> rd.shift);
               end else begin
                  want = colour_mem[rd.first_addr];
               end
               expected_colours.push_back(want);
               if (beat.track_length == LEN_CONSTANT) begin
                  constant_seen++;
               end else if (beat.blend == BLEND_DIRECT) begin
                  direct_seen++;
               end else if (rd.blended) begin
                  blended_seen++;
               end else begin
                  tail_seen++;
               end
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_colours.size() == 0) begin
               failures++;
               if (failures <= REPORT_MAX) begin
                  $display("%0t: colour_value %0d arrived with no sample outstanding",
                           $time, rsp_bus.colour_value);
               end
            end else begin
               want = expected_colours.pop_front();
               if (rsp_bus.colour_value !== want) begin
                  failures++;
                  if (failures <= REPORT_MAX) begin
                     $display("%0t: colour_value mismatch, expected %0d, actual %0d",
                              $time, want, rsp_bus.colour_value);
                  end
               end
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("run stopped after %0d cycles with %0d colors outstanding",
                  cycle_count, expected_colours.size());
         $display("colour_keyframe_sampler_tb: errors");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned        fc_plan [PHASES];
      int unsigned        fc;
      int unsigned        roll;
      int unsigned        phase_goal;
      bit                 paused;
      logic [FRAME_W-1:0] frame;
      logic [LEN_W-1:0]   len;

      csr_bus.valid = 1'b0;
      csr_bus.data  = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part, first with the frame total at its reset value of one, so that every
      // interpolated track is already at its last keyframe.
      queue_write('0, 8'hFF);
      queue_write(TOP_INDEX, 8'h00);
      queue_sample(TOP_INDEX, 16'hFFFF, 3'd5, LEN_CONSTANT);
      queue_sample('0, 16'h0000, 3'd0, LEN_CONSTANT);
      // Direct tracks whose address runs past the top of the table and wraps to zero.
      queue_sample(TOP_INDEX, 16'd1, BLEND_DIRECT, 16'd0);
      queue_sample(12'd1, 16'hFFFF, BLEND_DIRECT, 16'hFFFF);
      queue_sample('0, 16'hFFFF, 3'd6, 16'd2);
      // A zero track length behaves like any other length except one.
      queue_sample('0, 16'h0000, 3'd0, 16'd0);
      queue_write(12'd2048, 8'hA5);
      drain(SETTLE);

      // Largest frame total: nearly every frame lies between two keys.
      write_frame_total(16'hFFFF);
      queue_write(12'd100, 8'hFF);
      queue_write(12'd101, 8'hFF);
      // Coarsest decimation with the largest weight on two full-scale keys.
      queue_sample(12'd100, 16'd3, 3'd7, 16'd8);
      queue_write(12'd200, 8'h00);
      queue_write(12'd201, 8'hFF);
      queue_sample(12'd200, 16'd1, 3'd2, 16'd3);
      queue_sample(12'd200, 16'd2, 3'd4, 16'd3);
      queue_sample(12'd200, 16'd1, 3'd0, 16'd3);
      // The second key of a blend wraps from the top entry to entry zero.
      queue_sample(TOP_INDEX, 16'd0, 3'd2, 16'd9);
      // Frames at or past the last key take the end-of-track path.
      queue_sample('0, 16'hFFFF, 3'd2, 16'd9);
      queue_sample('0, 16'hFFFE, 3'd0, 16'd9);
      drain(SETTLE);

      // Zero frame total puts every frame past the end of the track.
      write_frame_total(16'h0000);
      queue_sample(12'd5, 16'd0, 3'd0, 16'd4);
      queue_sample(TOP_INDEX, 16'hFFFF, 3'd6, 16'hFFFF);
      drain(SETTLE);

      // Random part. Each phase runs under its own frame total; the first two phases have
      // a mostly stalled receiver, the next two a mostly idle sender, the last two neither.
      fc_plan = '{1, $urandom_range(40, 2), 65535, 0, $urandom_range(65534, 41),
                  $urandom_range(65535, 1)};
      for (int p = 0; p < PHASES; p++) begin
         send_idle_pct    = (p < 2) ? 30 : (p < 4) ? 65 : 0;
         accept_stall_pct = (p < 2) ? 65 : (p < 4) ? 30 : 0;
         fc = fc_plan[p];
         write_frame_total(COUNT_W'(fc));
         // A phase counts every beat it queues, the fill writes included.
         phase_goal = beats_queued + PHASE_BEATS;
         paused     = 1'b0;
         while (beats_queued < phase_goal) begin
            // Halfway through one phase the sender waits for every color to come back.
            if (p == 1 && !paused && beats_queued + PHASE_BEATS / 2 >= phase_goal) begin
               paused = 1'b1;
               drain(0);
            end
            if ($urandom_range(99) < 30) begin
               // Half the writes land close to the last track, so samples see fresh data.
               queue_write(INDEX_W'($urandom_range(1) ? $urandom_range(CKS_TABLE_DEPTH - 1)
                                                      : last_base + $urandom_range(15)),
                           BYTE_W'($urandom_range(255)));
            end else begin
               // Mostly frames below the total, some right around the last key, some wild.
               roll = $urandom_range(99);
               if (fc != 0 && roll < 60) begin
                  frame = FRAME_W'($urandom_range(fc - 1));
               end else if (roll < 80) begin
                  frame = FRAME_W'(fc + $urandom_range(4) - 3);
               end else begin
                  frame = FRAME_W'($urandom);
               end
               roll = $urandom_range(99);
               len  = (roll < 15) ? 16'd1 : (roll < 25) ? 16'd0 : 16'($urandom);
               last_base = $urandom_range(CKS_TABLE_DEPTH - 1);
               queue_sample(INDEX_W'(last_base), frame, BLEND_W'($urandom_range(7)), len);
            end
         end
         drain(SETTLE);
      end

      failures += expected_colours.size();
      $display("Checked %0d samples (%0d constant, %0d direct, %0d end-of-track, %0d blended)",
               constant_seen + direct_seen + tail_seen + blended_seen,
               constant_seen, direct_seen, tail_seen, blended_seen);
      $display("and %0d table writes over %0d frame total settings and three idle mixes.",
               writes_seen, settings_used + 1);
      if (failures == 0) begin
         $display("colour_keyframe_sampler_tb: clean");
      end else begin
         $display("colour_keyframe_sampler_tb: errors");
      end
      $finish;
   end

endmodule
